// File: hdl/pibd_pkg.sv
// Shared types and constants of the predictive image byte decoder.
package pibd_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 32;
    localparam int BYTE_W    = 8;
    // Code table byte count is ((H-1)*W)/4 of two CFG_W-bit values.
    localparam int TB_W      = 2 * CFG_W - 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd768;

    typedef logic [1:0] t_code;

    localparam t_code CODE_DIFF8  = 2'd0;
    localparam t_code CODE_DIFF16 = 2'd1;
    localparam t_code CODE_DIFF32 = 2'd2;
    localparam t_code CODE_REPEAT = 2'd3;

    typedef enum logic [2:0] {
        PH_TABLE = 3'b001,
        PH_RAW   = 3'b010,
        PH_DIFF  = 3'b100
    } t_phase;

    typedef struct packed {
        logic restart;
        logic preload;
        logic take;
    } t_cs_ctl;

endpackage

// File: hdl/pibd_code_store.sv
// Code table memory with a one-byte read-ahead that serves one 2-bit code per cycle while i_ctl.take is set.
module pibd_code_store #(
    parameter int DEPTH = 262144,
    parameter int IDX_W = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pibd_pkg::t_cs_ctl             i_ctl,
    input  logic                          i_wr_en,
    input  logic [IDX_W-1:0]              i_wr_idx,
    input  logic [pibd_pkg::BYTE_W-1:0]   i_wr_data,
    input  logic [pibd_pkg::TB_W-1:0]     i_table_bytes,
    output pibd_pkg::t_code               o_code
);
    import pibd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        PRE_IDLE  = 3'b001,
        PRE_FETCH = 3'b010,
        PRE_DONE  = 3'b100
    } t_pre;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_q;
    logic [IDX_W-1:0]  r_pf_idx, n_pf_idx;
    logic [BYTE_W-1:0] r_cur, n_cur;
    logic [1:0]        r_sub, n_sub;
    t_pre              r_pre, n_pre;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [BYTE_W-1:0] q_masked;

    // Bytes past the stored table read as code zero.
    assign q_masked = (r_pf_idx < IDX_W'(i_table_bytes)) ? r_rd_q : '0;
    assign o_code   = r_cur[{r_sub, 1'b0} +: 2];

    always_comb begin
        n_pf_idx = r_pf_idx;
        n_cur    = r_cur;
        n_sub    = r_sub;
        n_pre    = r_pre;
        rd_en    = 1'b0;
        rd_idx   = r_pf_idx + 1'b1;
        if (i_ctl.restart) begin
            n_pre    = PRE_IDLE;
            n_sub    = '0;
            n_cur    = '0;
            n_pf_idx = '0;
        end else begin
            unique case (r_pre)
                PRE_IDLE: begin
                    if (i_ctl.preload) begin
                        rd_en    = 1'b1;
                        rd_idx   = '0;
                        n_pf_idx = '0;
                        n_pre    = PRE_FETCH;
                    end
                end
                PRE_FETCH: begin
                    n_cur    = q_masked;
                    rd_en    = 1'b1;
                    n_pf_idx = rd_idx;
                    n_pre    = PRE_DONE;
                end
                PRE_DONE: begin
                    if (i_ctl.take) begin
                        n_sub = r_sub + 1'b1;
                        // Last code of this byte: swap in the read-ahead byte, fetch the next.
                        if (r_sub == 2'd3) begin
                            n_cur    = q_masked;
                            rd_en    = 1'b1;
                            n_pf_idx = rd_idx;
                        end
                    end
                end
                default: n_pre = PRE_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx[AW-1:0]] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre    <= PRE_IDLE;
            r_sub    <= '0;
            r_cur    <= '0;
            r_pf_idx <= '0;
        end else begin
            r_pre    <= n_pre;
            r_sub    <= n_sub;
            r_cur    <= n_cur;
            r_pf_idx <= n_pf_idx;
        end
    end

endmodule

// File: hdl/pibd_row_store.sv
// One-row pixel memory: one write and one registered read per cycle.
module pibd_row_store #(
    parameter int DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  logic [pibd_pkg::PIX_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    output logic [pibd_pkg::PIX_W-1:0]  o_rd_data
);
    import pibd_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_q;

    assign o_rd_data = r_rd_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: hdl/predictive_image_byte_decoder.sv
// Top level of the predictive image byte decoder: byte parsing, prediction and output stage.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------------------
//  input     in         i_in_valid / o_in_stall   i_data_byte
//  output    out        o_out_valid / i_out_stall o_pixel_value, o_last_pixel
//  config    in         i_cfg_we (write only)     i_cfg_index, i_cfg_data
//
//  One byte is taken every clock cycle unless o_in_stall is high. A pixel reaches
//  the output register in the cycle after the byte that completes it; a repeat-code
//  pixel uses one byte slot and ignores that byte. The code memory and the row memory
//  each do at most one read and one write per cycle; a one-byte read-ahead on the code
//  memory and a next-column read-ahead on the row memory keep memory reads off the
//  per-byte path. Reset is synchronous and clears control state only; both memories
//  hold garbage until a frame writes them, and no clearing pass runs.
//  The input stalls only while the output register is full and stalled.
module predictive_image_byte_decoder #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pibd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pibd_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [pibd_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pibd_pkg::PIX_W-1:0]        o_pixel_value,
    output logic                              o_last_pixel
);
    import pibd_pkg::*;

    localparam int CODE_DEPTH = MAX_WIDTH * MAX_HEIGHT / 4;
    localparam int CA         = $clog2(CODE_DEPTH);
    localparam int IDX_W      = ((CA > TB_W) ? CA : TB_W) + 1;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int CMP_A      = (CW > RW) ? CW : RW;
    localparam int CMP_W      = ((CMP_A > CFG_W) ? CMP_A : CFG_W) + 1;

    // Configuration
    logic [CFG_W-1:0]   r_cfg_w, r_cfg_h;
    logic [CFG_W-1:0]   eff_w, eff_h;
    logic [2*CFG_W-1:0] prod;
    logic [TB_W-1:0]    table_bytes;
    logic               table_empty;

    // Frame state
    t_phase             r_phase, n_phase, ph;
    logic [PIX_W-1:0]   r_left, n_left;
    logic [PIX_W-1:0]   r_al, n_al;
    logic [23:0]        r_asm, n_asm;
    logic [1:0]         r_pend, n_pend;
    logic [PIX_W-1:0]   r_prev, n_prev;
    t_code              r_code, n_code;
    logic [TB_W-1:0]    r_tcnt, n_tcnt;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;

    // Output register
    logic               r_ov;
    logic [PIX_W-1:0]   r_opix;
    logic               r_olast;

    logic               acc;
    logic               emit;
    logic [PIX_W-1:0]   emit_val;
    logic               last;
    logic               col_end;
    logic               restart;
    logic [PIX_W-1:0]   word;
    logic [PIX_W-1:0]   above;
    logic [PIX_W-1:0]   row_q;
    logic [PIX_W-1:0]   diff;
    logic [PIX_W-1:0]   pred;
    logic               diff_done;
    t_code              cs_code;
    t_code              code_now;
    t_cs_ctl            cs_ctl;
    logic               tbl_we;
    logic [TB_W-1:0]    tcnt_inc;
    logic [CW-1:0]      rd_col;

    // Clamp the frame size and derive the code table length.
    assign eff_w = (r_cfg_w < CFG_W'(2)) ? CFG_W'(2) :
                   ((32'(r_cfg_w) > 32'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : r_cfg_w);
    assign eff_h = (r_cfg_h < CFG_W'(2)) ? CFG_W'(2) :
                   ((32'(r_cfg_h) > 32'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : r_cfg_h);
    assign prod        = (2*CFG_W)'(eff_h - 1'b1) * (2*CFG_W)'(eff_w);
    assign table_bytes = prod[2*CFG_W-1:2];
    assign table_empty = (table_bytes == '0);

    // An empty code table starts the frame straight at the raw pixels.
    assign ph = (r_phase == PH_TABLE && table_empty) ? PH_RAW : r_phase;

    assign o_in_stall    = r_ov & i_out_stall;
    assign acc           = i_in_valid & ~o_in_stall;
    assign o_out_valid   = r_ov;
    assign o_pixel_value = r_opix;
    assign o_last_pixel  = r_olast;

    // Little-endian assembly of the pending bytes with the incoming one.
    always_comb begin
        case (r_pend)
            2'd0:    word = {24'd0, i_data_byte};
            2'd1:    word = {16'd0, i_data_byte, r_asm[7:0]};
            2'd2:    word = {8'd0, i_data_byte, r_asm[15:0]};
            default: word = {i_data_byte, r_asm};
        endcase
    end

    assign code_now = (r_pend == 2'd0) ? cs_code : r_code;

    always_comb begin
        unique case (code_now)
            CODE_DIFF8: begin
                diff      = {{24{word[7]}}, word[7:0]};
                diff_done = (r_pend == 2'd0);
            end
            CODE_DIFF16: begin
                diff      = {{16{word[15]}}, word[15:0]};
                diff_done = (r_pend == 2'd1);
            end
            CODE_DIFF32: begin
                diff      = word;
                diff_done = (r_pend == 2'd3);
            end
            default: begin
                diff      = r_prev;
                diff_done = 1'b1;
            end
        endcase
    end

    // Top row has nothing above it.
    assign above = (r_row == '0) ? '0 : row_q;
    assign pred  = r_left + above + diff - r_al;

    assign col_end  = (CMP_W'(r_col) + 1'b1 == CMP_W'(eff_w));
    assign last     = col_end && (CMP_W'(r_row) + 1'b1 == CMP_W'(eff_h));
    assign tcnt_inc = r_tcnt + 1'b1;
    assign rd_col   = col_end ? '0 : r_col + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_al     = r_al;
        n_asm    = r_asm;
        n_pend   = r_pend;
        n_prev   = r_prev;
        n_code   = r_code;
        n_tcnt   = r_tcnt;
        n_row    = r_row;
        n_col    = r_col;
        emit     = 1'b0;
        emit_val = '0;
        tbl_we   = 1'b0;
        cs_ctl   = '0;

        if (acc) begin
            unique case (ph)
                PH_TABLE: begin
                    tbl_we = 1'b1;
                    if (tcnt_inc == table_bytes) begin
                        n_phase = PH_RAW;
                        n_tcnt  = '0;
                    end else begin
                        n_tcnt = tcnt_inc;
                    end
                end
                PH_RAW: begin
                    if (r_pend == 2'd3) begin
                        emit     = 1'b1;
                        emit_val = word;
                        n_asm    = '0;
                        n_pend   = '0;
                    end else begin
                        n_asm  = word[23:0];
                        n_pend = r_pend + 1'b1;
                    end
                end
                PH_DIFF: begin
                    if (r_pend == 2'd0) begin
                        cs_ctl.take = 1'b1;
                        n_code      = cs_code;
                    end
                    if (diff_done) begin
                        emit     = 1'b1;
                        emit_val = pred;
                        n_prev   = diff;
                        n_asm    = '0;
                        n_pend   = '0;
                    end else begin
                        n_asm  = word[23:0];
                        n_pend = r_pend + 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (emit) begin
            n_al   = above;
            n_left = emit_val;
            if (col_end) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
            // The pixel after the first one of the second row starts prediction.
            if (ph == PH_RAW && r_row == RW'(1) && r_col == '0) begin
                n_phase = PH_DIFF;
            end
        end

        cs_ctl.preload = (ph == PH_RAW);

        // Frame restart: after the flagged pixel or on any register write.
        restart = (emit && last) || i_cfg_we;
        if (restart) begin
            n_phase = PH_TABLE;
            n_left  = '0;
            n_al    = '0;
            n_asm   = '0;
            n_pend  = '0;
            n_prev  = '0;
            n_code  = CODE_DIFF8;
            n_tcnt  = '0;
            n_row   = '0;
            n_col   = '0;
        end
        cs_ctl.restart = restart;
    end

    pibd_code_store #(
        .DEPTH (CODE_DEPTH),
        .IDX_W (IDX_W)
    ) u_code_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (cs_ctl),
        .i_wr_en       (tbl_we),
        .i_wr_idx      (IDX_W'(r_tcnt)),
        .i_wr_data     (i_data_byte),
        .i_table_bytes (table_bytes),
        .o_code        (cs_code)
    );

    // Write the finished pixel at its column and read ahead the next column.
    pibd_row_store #(
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (emit),
        .i_wr_addr (r_col),
        .i_wr_data (emit_val),
        .i_rd_en   (emit),
        .i_rd_addr (rd_col),
        .o_rd_data (row_q)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RST;
            r_cfg_h <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data;
            endcase
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TABLE;
            r_left  <= '0;
            r_al    <= '0;
            r_asm   <= '0;
            r_pend  <= '0;
            r_prev  <= '0;
            r_code  <= CODE_DIFF8;
            r_tcnt  <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_al    <= n_al;
            r_asm   <= n_asm;
            r_pend  <= n_pend;
            r_prev  <= n_prev;
            r_code  <= n_code;
            r_tcnt  <= n_tcnt;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // Output register: load on a pixel, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_opix  <= emit_val;
            r_olast <= last;
        end
    end

    a_diff_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIFF) |-> (r_row != '0))
        else $error("prediction phase on the top row");

    a_table_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TABLE && !table_empty) |->
            (r_pend == '0 && r_row == '0 && r_col == '0))
        else $error("pixel state not clear while loading code table");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_phase == PH_TABLE && r_row == '0 && r_col == '0 && r_pend == '0))
        else $error("frame did not restart after last pixel");

    a_no_repeat_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIFF && r_pend != 2'd0) |-> (r_code != CODE_REPEAT))
        else $error("repeat code with bytes pending");

endmodule
